FILE: sv/vpc_pkg.sv
// Shared types and constants for the valve pulse controller.
// Has no dependencies; the decision logic and the top level import it.
package vpc_pkg;

   localparam int TEMP_W  = 15;
   localparam int TREND_W = 9;
   localparam int TIME_W  = 32;
   localparam int PULSE_W = 16;
   localparam int BAND_W  = 10;
   localparam int GAIN_W  = 10;
   localparam int CSR_W   = 3;
   localparam int DATA_W  = 16;

   localparam logic signed [TEMP_W-1:0]  NO_READING  = -15'sd4368;
   localparam logic signed [TREND_W-1:0] TREND_LIMIT = 9'sd70;

   localparam logic [CSR_W-1:0] CSR_TARGET_TEMP    = 3'd0;
   localparam logic [CSR_W-1:0] CSR_DEADBAND       = 3'd1;
   localparam logic [CSR_W-1:0] CSR_GAIN           = 3'd2;
   localparam logic [CSR_W-1:0] CSR_HOLD_OFF       = 3'd3;
   localparam logic [CSR_W-1:0] CSR_SHORTEST_PULSE = 3'd4;
   localparam logic [CSR_W-1:0] CSR_LONGEST_PULSE  = 3'd5;

   typedef enum logic [1:0] {
      ACTION_NONE = 2'd0,
      ACTION_UP   = 2'd1,
      ACTION_DOWN = 2'd2
   } action_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] target_temp;
      logic [BAND_W-1:0]        deadband;
      logic [GAIN_W-1:0]        gain_per_degree;
      logic [PULSE_W-1:0]       hold_off_time;
      logic [PULSE_W-1:0]       shortest_pulse;
      logic [PULSE_W-1:0]       longest_pulse;
   } config_type;

   typedef struct packed {
      logic [TIME_W-1:0]         timestamp;
      logic signed [TEMP_W-1:0]  measured_temp;
      logic signed [TREND_W-1:0] trend_direction;
      logic signed [TREND_W-1:0] trend_rate;
   } sample_type;

   typedef struct packed {
      action_type         action;
      logic [PULSE_W-1:0] pulse_length;
      logic               move;
   } decision_type;

endpackage

FILE: sv/vpc_decide.sv
// Combinational decision logic for one registered sample request.
// Depends on vpc_pkg for the configuration, sample and decision types.
module vpc_decide
   import vpc_pkg::*;
(
   input  config_type         cfg,
   input  sample_type         sample,
   input  logic [TIME_W-1:0]  last_move_time,
   output decision_type       decision
);

   logic signed [16:0] err;
   logic signed [16:0] band;
   logic signed [16:0] neg_band;
   logic [15:0]        mag;
   logic [25:0]        product;
   logic [22:0]        pulse_sum;
   logic [PULSE_W-1:0] pulse;
   logic [TIME_W-1:0]  dt;
   logic [32:0]        dt_plus_one;
   logic [35:0]        dt_scaled;
   logic [19:0]        hold_scaled;
   logic [16:0]        twice_short;
   logic [17:0]        thrice_short;
   logic               too_cold;
   logic               too_hot;
   logic               up_ready;
   logic               down_ready;
   logic               up_suppress;
   logic               down_suppress;
   logic               dir_pos;
   logic               dir_neg;
   logic               dir_ne_vel;

   always_comb begin
      err      = $signed({{2{cfg.target_temp[TEMP_W-1]}}, cfg.target_temp})
               - $signed({{2{sample.measured_temp[TEMP_W-1]}}, sample.measured_temp});
      band     = $signed({7'd0, cfg.deadband});
      neg_band = 17'sd0 - band;
      mag      = err[16] ? 16'(-err) : err[15:0];

      // The error is in 1/16 degree, so the gain product drops four fraction bits.
      product   = {10'd0, mag} * {16'd0, cfg.gain_per_degree};
      pulse_sum = {7'd0, cfg.shortest_pulse} + {1'b0, product[25:4]};
      pulse     = (pulse_sum > {7'd0, cfg.longest_pulse}) ? cfg.longest_pulse
                                                           : pulse_sum[PULSE_W-1:0];

      // The down move needs 10*dt > 13*hold - 10, taken as 10*(dt+1) > 13*hold.
      dt          = sample.timestamp - last_move_time;
      dt_plus_one = {1'b0, dt} + 33'd1;
      dt_scaled   = {dt_plus_one, 3'b000} + {2'b00, dt_plus_one, 1'b0};
      hold_scaled = {1'b0, cfg.hold_off_time, 3'b000} + {2'b00, cfg.hold_off_time, 2'b00}
                  + {4'd0, cfg.hold_off_time};
      up_ready    = dt >= {16'd0, cfg.hold_off_time};
      down_ready  = dt_scaled > {16'd0, hold_scaled};

      too_cold = (sample.measured_temp != NO_READING) && (err > band);
      too_hot  = (sample.measured_temp != NO_READING) && (err < neg_band);

      twice_short  = {cfg.shortest_pulse, 1'b0};
      thrice_short = {1'b0, cfg.shortest_pulse, 1'b0} + {2'b00, cfg.shortest_pulse};
      dir_pos      = sample.trend_direction > 9'sd0;
      dir_neg      = sample.trend_direction < 9'sd0;
      dir_ne_vel   = sample.trend_direction != sample.trend_rate;

      up_suppress   = ({1'b0, pulse} < twice_short)
                    && (dir_pos || (dir_ne_vel && (sample.trend_rate > TREND_LIMIT)));
      down_suppress = ({2'b00, pulse} < thrice_short)
                    && (dir_neg || (dir_ne_vel && (sample.trend_rate < -TREND_LIMIT)));

      decision.action       = ACTION_NONE;
      decision.pulse_length = '0;
      decision.move         = 1'b0;
      if (too_cold && up_ready) begin
         decision.move = 1'b1;
         if (!up_suppress) begin
            decision.action       = ACTION_UP;
            decision.pulse_length = pulse;
         end
      end else if (too_hot && down_ready) begin
         decision.move = 1'b1;
         if (!down_suppress) begin
            decision.action       = ACTION_DOWN;
            decision.pulse_length = pulse;
         end
      end
   end

endmodule

FILE: sv/valve_pulse_controller_core.sv
// Valve pulse controller: one decision per sample request.
// A request is held in the sample registers and decided combinationally; its result is then registered.
// Throughput is one request per cycle unless rsp_stall holds the output; the last move time is
// updated in the same cycle a result is registered, so back-to-back requests see it in order.
// Synchronous active-high reset clears the valid flags, the last move time
// and the configuration registers to their defaults. Depends on vpc_pkg and vpc_decide.
module valve_pulse_controller_core
   import vpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_W-1:0]           csr_index,
   input  logic [DATA_W-1:0]          csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [TIME_W-1:0]          req_timestamp,
   input  logic signed [TEMP_W-1:0]   req_measured_temp,
   input  logic signed [TREND_W-1:0]  req_trend_direction,
   input  logic signed [TREND_W-1:0]  req_trend_rate,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_action,
   output logic [PULSE_W-1:0]         rsp_pulse_length
);

   config_type         cfg_ff;
   config_type         cfg_in;
   sample_type         sample_ff;
   logic               in_valid_ff;
   logic               rsp_valid_ff;
   decision_type       decision;
   action_type         action_ff;
   logic [PULSE_W-1:0] pulse_ff;
   logic [TIME_W-1:0]  last_move_ff;
   logic [TIME_W-1:0]  last_move_in;
   logic               out_free;
   logic               fire;
   logic               req_take;

   vpc_decide u_decide (
      .cfg            (cfg_ff),
      .sample         (sample_ff),
      .last_move_time (last_move_ff),
      .decision       (decision)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TARGET_TEMP:    cfg_in.target_temp     = $signed(csr_write_data[TEMP_W-1:0]);
            CSR_DEADBAND:       cfg_in.deadband        = csr_write_data[BAND_W-1:0];
            CSR_GAIN:           cfg_in.gain_per_degree = csr_write_data[GAIN_W-1:0];
            CSR_HOLD_OFF:       cfg_in.hold_off_time   = csr_write_data;
            CSR_SHORTEST_PULSE: cfg_in.shortest_pulse  = csr_write_data;
            CSR_LONGEST_PULSE:  cfg_in.longest_pulse   = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
      last_move_in = (fire && decision.move) ? sample_ff.timestamp : last_move_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp     <= NO_READING;
         cfg_ff.deadband        <= '0;
         cfg_ff.gain_per_degree <= '0;
         cfg_ff.hold_off_time   <= '0;
         cfg_ff.shortest_pulse  <= '0;
         cfg_ff.longest_pulse   <= '0;
         last_move_ff           <= '0;
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         last_move_ff <= last_move_in;
         if (!in_valid_ff || out_free) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff.timestamp       <= req_timestamp;
         sample_ff.measured_temp   <= req_measured_temp;
         sample_ff.trend_direction <= req_trend_direction;
         sample_ff.trend_rate      <= req_trend_rate;
      end
      if (fire) begin
         action_ff <= decision.action;
         pulse_ff  <= decision.pulse_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_pulse_length = pulse_ff;

   a_idle_zero_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (action_ff == ACTION_NONE) |-> (pulse_ff == '0))
      else $error("result with no action carries a nonzero pulse length");

   a_move_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      !$stable(last_move_ff) |-> ($past(fire) || $past(reset)))
      else $error("last move time changed without a result being registered");

   a_move_takes_timestamp: assert property (@(posedge clock) disable iff (reset)
      fire && decision.move |=> (last_move_ff == $past(sample_ff.timestamp)))
      else $error("last move time did not take the request timestamp");

   a_action_has_move: assert property (@(posedge clock) disable iff (reset)
      fire && (decision.action != ACTION_NONE) |=> (last_move_ff == $past(sample_ff.timestamp)))
      else $error("valve pulse issued without recording the move time");

endmodule
